// ----- sv/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Item types, command and status codes, register index and sequencer states.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_ALLOCATED = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_FREED     = 2'd2;
  localparam logic [1:0] STAT_RANGE     = 2'd3;

  localparam logic REG_BITMAP_BLOCKS = 1'b0;

  typedef struct packed {
    logic        cmd;
    logic [13:0] block_number;
  } in_item_t;

  typedef struct packed {
    logic [13:0] allocated_block;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_START,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } bba_state_t;

endpackage

// ----- sv/bba_ram.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- sv/bitmap_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Bitmap block allocator core
// First-fit allocator over a bitmap of used blocks, one bit per block, held
// in 64-bit words of a RAM and scanned one word per cycle.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_item_t  (cmd, block_number)
//  out      output     out_valid / out_stall  out_item_t (allocated_block, status)
//  cfg      input      APB write, pready = 1  bitmap_blocks at byte address 0
//
// An allocate scans the words in use in turn through the single RAM read port;
// an in-range free reads its word and writes it back, and a free out of range
// or an allocate with no bitmap in use goes straight to its result.
// After reset a clearing pass writes all MAX_BITMAP_BLOCKS*BLOCK_BYTES/8 RAM words,
// one per cycle, during which no item is accepted.
// One item is in work at a time; a finished result waits in the output
// register while out_stall is high, and the next item may be taken meanwhile.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core
  import bba_pkg::*;
#(
  parameter int BLOCK_BYTES       = 1024,
  parameter int MAX_BITMAP_BLOCKS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WPB       = BLOCK_BYTES / 8;
  localparam int MAP_WORDS = MAX_BITMAP_BLOCKS * WPB;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WUW       = $clog2(MAP_WORDS + 1);
  localparam int LW        = (WUW + 6 > 14) ? WUW + 6 : 14;

  bba_state_t       state_r, state_nxt;
  logic [1:0]       bitmap_blocks_r;
  logic [AW-1:0]    chk_addr_r;
  logic             out_valid_r;
  logic [13:0]      blk_r;
  out_item_t        res_r;
  out_item_t        out_r;

  logic [4:0]       lim_blocks;
  logic [WUW-1:0]   words_in_use;
  logic             blk_in_range;
  logic             accept;
  logic             out_free;
  logic             scan_last;
  logic             clear_last;
  logic [63:0]      rd_word;
  logic [63:0]      iso;
  logic             found;
  logic [5:0]       found_bit;

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [63:0]      ram_wr_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;

  bba_ram #(
    .WIDTH (64),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_word)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BITMAP_BLOCKS) ? {30'd0, bitmap_blocks_r} : 32'd0;

  assign lim_blocks   = (5'(bitmap_blocks_r) > 5'(MAX_BITMAP_BLOCKS)) ?
                        5'(MAX_BITMAP_BLOCKS) : 5'(bitmap_blocks_r);
  assign words_in_use = WUW'(32'(lim_blocks) * WPB);
  assign blk_in_range = LW'(in_data.block_number) < LW'({words_in_use, 6'd0});

  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign scan_last  = (WUW'(chk_addr_r) + WUW'(1)) == words_in_use;
  assign clear_last = chk_addr_r == AW'(MAP_WORDS - 1);

  assign iso   = ~rd_word & (rd_word + 64'd1);
  assign found = |iso;

  always_comb begin
    found_bit = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (iso[i]) begin
        found_bit = found_bit | 6'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_FREE) begin
            state_nxt = blk_in_range ? S_FREE_RD : S_DONE;
          end else begin
            state_nxt = (words_in_use == '0) ? S_DONE : S_SCAN_START;
          end
        end
      end
      S_SCAN_START: state_nxt = S_SCAN;
      S_SCAN: begin
        if (found || scan_last) state_nxt = S_DONE;
      end
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    ram_wr_en   = 1'b0;
    ram_wr_addr = chk_addr_r;
    ram_wr_data = 64'd0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = chk_addr_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_SCAN_START: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = '0;
      end
      S_SCAN: begin
        ram_wr_en   = found;
        ram_wr_data = rd_word | iso;
        ram_rd_en   = !found && !scan_last;
        ram_rd_addr = chk_addr_r + AW'(1);
      end
      S_FREE_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = AW'(blk_r[13:6]);
      end
      S_FREE_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = AW'(blk_r[13:6]);
        ram_wr_data = rd_word & ~(64'd1 << blk_r[5:0]);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      chk_addr_r      <= '0;
      out_valid_r     <= 1'b0;
      bitmap_blocks_r <= 2'd1;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && paddr[2] == REG_BITMAP_BLOCKS) begin
        bitmap_blocks_r <= pwdata[1:0];
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      priority case (state_r)
        S_CLEAR:      chk_addr_r <= chk_addr_r + AW'(1);
        S_SCAN_START: chk_addr_r <= '0;
        S_SCAN: begin
          if (!found && !scan_last) chk_addr_r <= chk_addr_r + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      blk_r <= in_data.block_number;
      if (in_data.cmd == CMD_FREE) begin
        res_r <= '{allocated_block: 14'd0, status: STAT_RANGE};
      end else begin
        res_r <= '{allocated_block: 14'd0, status: STAT_FULL};
      end
    end
    if (state_r == S_SCAN) begin
      if (found) begin
        res_r <= '{allocated_block: 14'({chk_addr_r, found_bit}), status: STAT_ALLOCATED};
      end else begin
        res_r <= '{allocated_block: 14'd0, status: STAT_FULL};
      end
    end
    if (state_r == S_FREE_WR) begin
      res_r <= '{allocated_block: 14'd0, status: STAT_FREED};
    end
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_wr_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (32'(ram_wr_addr) < MAP_WORDS))
    else $error("Bitmap write address lies beyond the map.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("A new item was taken while the previous one was in work.");

  a_alloc_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_ALLOCATED) |->
      (LW'(out_data.allocated_block) < LW'({words_in_use, 6'd0})))
    else $error("Allocated block lies beyond the bitmap in use.");

  a_zero_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_ALLOCATED) |-> (out_data.allocated_block == 14'd0))
    else $error("Block number is not zero on a result that allocated nothing.");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate and free items through the core, writes the bitmap-blocks
// register between phases, and checks every result against a first-fit
// model of the used-block map kept here or a result listed for the step.
// A short list of directed steps precedes random phases at each register setting.
// ----------------------------------------------------------------------------
module tb;
  import bba_pkg::*;

  localparam int BLOCK_BYTES       = 1024;
  localparam int MAX_BITMAP_BLOCKS = 2;
  localparam int BITS_PER_BITMAP   = BLOCK_BYTES * 8;
  localparam int MAP_WORDS         = MAX_BITMAP_BLOCKS * BLOCK_BYTES / 8;

  localparam logic [2:0] ADDR_BITMAP_BLOCKS = 3'(REG_BITMAP_BLOCKS) << 2;
  localparam logic [2:0] ADDR_UNUSED        = 3'd4;

  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLDOFF_AT     = 400;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int STEADY_FIRST   = 700;
  localparam int STEADY_LAST    = 900;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  addr;
    logic [31:0] wdata;
    in_item_t    item;
    bit          typed;
    out_item_t   result;
  } step_t;

  localparam int NUM_DIRECTED = 24;

  step_t directed_steps [NUM_DIRECTED] = '{
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_ALLOC, 14'd0},     1'b1, '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_ALLOC, 14'd16383}, 1'b1, '{14'd1, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_ALLOC, 14'd0},     1'b0, '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd0},     1'b1, '{14'd0, STAT_FREED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd0},     1'b1, '{14'd0, STAT_FREED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_ALLOC, 14'd0},     1'b1, '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd8191},  1'b1, '{14'd0, STAT_FREED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd8192},  1'b1, '{14'd0, STAT_RANGE}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd16383}, 1'b1, '{14'd0, STAT_RANGE}},
    '{ROW_WRITE, ADDR_BITMAP_BLOCKS, 32'd0, '{CMD_ALLOC, 14'd0}, 1'b0, '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_ALLOC, 14'd0},     1'b1, '{14'd0, STAT_FULL}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd0},     1'b1, '{14'd0, STAT_RANGE}},
    '{ROW_WRITE, ADDR_BITMAP_BLOCKS, 32'd3, '{CMD_ALLOC, 14'd0}, 1'b0, '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd16383}, 1'b1, '{14'd0, STAT_FREED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd8192},  1'b1, '{14'd0, STAT_FREED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_ALLOC, 14'd0},     1'b0, '{14'd0, STAT_ALLOCATED}},
    '{ROW_WRITE, ADDR_UNUSED, 32'd0, '{CMD_ALLOC, 14'd0}, 1'b0, '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_ALLOC, 14'd0},     1'b0, '{14'd0, STAT_ALLOCATED}},
    '{ROW_WRITE, ADDR_BITMAP_BLOCKS, 32'd2, '{CMD_ALLOC, 14'd0}, 1'b0, '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd12345}, 1'b1, '{14'd0, STAT_FREED}},
    '{ROW_WRITE, ADDR_BITMAP_BLOCKS, 32'hFFFF_FFFD, '{CMD_ALLOC, 14'd0}, 1'b0,
      '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_ALLOC, 14'd0},     1'b0, '{14'd0, STAT_ALLOCATED}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd9000},  1'b1, '{14'd0, STAT_RANGE}},
    '{ROW_ITEM,  3'd0, 32'd0, '{CMD_FREE,  14'd1},     1'b1, '{14'd0, STAT_FREED}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [63:0] used_map [MAP_WORDS];
  logic [1:0]  blocks_setting;
  out_item_t   pending_results [$];
  logic [13:0] taken_blocks [$];

  int unsigned items_sent = 0;
  int unsigned error_count = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  int unsigned quiet_cycles = 0;

  bitmap_block_allocator_core #(
    .BLOCK_BYTES      (BLOCK_BYTES),
    .MAX_BITMAP_BLOCKS(MAX_BITMAP_BLOCKS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic bit steady_window();
    return items_sent >= STEADY_FIRST && items_sent < STEADY_LAST;
  endfunction

  function automatic int unsigned bits_in_use();
    int unsigned n;
    n = blocks_setting;
    if (n > MAX_BITMAP_BLOCKS) n = MAX_BITMAP_BLOCKS;
    return n * BITS_PER_BITMAP;
  endfunction

  // First fit over the used-block map: word n/64, bit n%64.
  function automatic out_item_t predict_result(in_item_t req);
    out_item_t   res;
    int unsigned limit;
    bit          found;
    res = '0;
    limit = bits_in_use();
    found = 1'b0;
    if (req.cmd == CMD_ALLOC) begin
      res.status = STAT_FULL;
      for (int unsigned n = 0; n < limit && !found; n++) begin
        if (!used_map[n / 64][n % 64]) begin
          used_map[n / 64][n % 64] = 1'b1;
          res.allocated_block = 14'(n);
          res.status = STAT_ALLOCATED;
          found = 1'b1;
        end
      end
    end else if (req.block_number < limit) begin
      used_map[req.block_number / 64][req.block_number % 64] = 1'b0;
      res.status = STAT_FREED;
    end else begin
      res.status = STAT_RANGE;
    end
    return res;
  endfunction

  // Allocates at alloc_pct percent; the frees are mostly of blocks handed out
  // earlier, some anywhere in the map in use, and the rest across the whole field.
  function automatic in_item_t random_request(int unsigned alloc_pct);
    in_item_t    req;
    int unsigned pick;
    int unsigned limit;
    int unsigned k;
    limit = bits_in_use();
    req.block_number = 14'($urandom);
    req.cmd = CMD_FREE;
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      req.cmd = CMD_ALLOC;
    end else begin
      pick = $urandom_range(99);
      if (pick < 60 && taken_blocks.size() > 0) begin
        k = $urandom_range(taken_blocks.size() - 1);
        req.block_number = taken_blocks[k];
        taken_blocks.delete(k);
      end else if (pick < 85 && limit > 0) begin
        req.block_number = 14'($urandom_range(limit - 1));
      end
    end
    return req;
  endfunction

  task automatic send_item(input in_item_t req, input bit typed, input out_item_t typed_result);
    out_item_t res;
    while (!steady_window() && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    items_sent++;
    res = predict_result(req);
    if (res.status == STAT_ALLOCATED) taken_blocks.push_back(res.allocated_block);
    pending_results.push_back(typed ? typed_result : res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if ((addr >> 2) == 3'(REG_BITMAP_BLOCKS)) blocks_setting = value[1:0];
  endtask

  task automatic run_phase(input logic [1:0] setting, input int unsigned count,
                           input int unsigned alloc_pct, input bit pause_mid);
    drain_results();
    write_reg(ADDR_BITMAP_BLOCKS, ($urandom & ~32'h3) | 32'(setting));
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) drain_results();
      send_item(random_request(alloc_pct), 1'b0, '0);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: allocated_block %0d status %0d",
             got.allocated_block, got.status);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.allocated_block !== want.allocated_block) begin
        $error("allocated_block: expected %0d, actual %0d",
               want.allocated_block, got.allocated_block);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        error_count++;
      end
    end
  endtask

  // The receiver holds off once for a long stretch so that the core backs up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_data);
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (!holdoff_done && items_sent >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_window() && ($urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (used_map[w]) used_map[w] = '0;
    blocks_setting = 2'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(directed_steps[i].addr, directed_steps[i].wdata);
      end else begin
        send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].result);
      end
    end

    run_phase(2'd1, 300, 60, 1'b0);
    run_phase(2'd2, 300, 50, 1'b1);
    run_phase(2'd3, 250, 45, 1'b0);
    run_phase(2'd0, 60, 50, 1'b0);
    run_phase(2'd1, 250, 40, 1'b0);
    run_phase(2'd2, 190, 55, 1'b0);

    drain_results();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bitmap_block_allocator_core.sv
test/tb.sv
